### src/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Shared constants for the Catmull-Rom interpolator pipeline.
// ----------------------------------------------------------------------------
package crr_pkg;

    // Default width of one control point coordinate (signed fixed point)
    localparam int COORD_WIDTH_DEF = 32;

    // Default number of fraction bits in the t parameter
    localparam int T_FRAC_BITS_DEF = 16;

    // Extra integer bits on top of the coordinate width for the cubic
    // coefficients and the Horner accumulator. The largest magnitude
    // reached is 24 times the coordinate range, so five bits suffice.
    localparam int ACC_GUARD_BITS = 5;

    // Number of coefficients carried alongside the accumulator: b, a, 2*p1
    localparam int COEF_COUNT = 3;

    // Coefficient slots in the carried bundle, in Horner order
    localparam int COEF_SEL_B  = 0;
    localparam int COEF_SEL_A  = 1;
    localparam int COEF_SEL_P1 = 2;

endpackage

### src/crr_horner_step.sv
// ----------------------------------------------------------------------------
// crr_horner_step
// One Horner step acc' = round(acc * t) + coef, in three register stages:
// multiply, round, signed add.
// ----------------------------------------------------------------------------
module crr_horner_step
    import crr_pkg::*;
#(
    parameter int ACC_W    = COORD_WIDTH_DEF + ACC_GUARD_BITS,
    parameter int T_FRAC   = T_FRAC_BITS_DEF,
    parameter int COEF_SEL = COEF_SEL_B
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic signed [ACC_W-1:0]       in_acc,
    input  logic [T_FRAC:0]               in_t,
    input  logic [COEF_COUNT*ACC_W-1:0]   in_coefs,
    output logic                          out_vld,
    output logic signed [ACC_W-1:0]       out_acc,
    output logic [T_FRAC:0]               out_t,
    output logic [COEF_COUNT*ACC_W-1:0]   out_coefs
);

    localparam int T_W    = T_FRAC + 1;
    localparam int PROD_W = ACC_W + T_W;
    localparam logic [PROD_W-1:0] RND_HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (T_FRAC - 1);

    // multiply stage
    logic                        vld_m_reg;
    logic                        neg_m_reg;
    logic [PROD_W-1:0]           prod_m_reg;
    logic [PROD_W-1:0]           prod_m_next;
    logic [T_W-1:0]              t_m_reg;
    logic [COEF_COUNT*ACC_W-1:0] coefs_m_reg;
    logic                        neg_in;
    logic [ACC_W-1:0]            sel_in;
    logic [T_W-1:0]              corr_in;

    // round stage
    logic                        vld_r_reg;
    logic                        neg_r_reg;
    logic [ACC_W-1:0]            mag_r_reg;
    logic [ACC_W-1:0]            mag_r_next;
    logic [PROD_W-1:0]           rnd_sum;
    logic [T_W-1:0]              t_r_reg;
    logic [COEF_COUNT*ACC_W-1:0] coefs_r_reg;

    // add stage
    logic                        vld_a_reg;
    logic signed [ACC_W-1:0]     acc_a_reg;
    logic signed [ACC_W-1:0]     acc_a_next;
    logic [T_W-1:0]              t_a_reg;
    logic [COEF_COUNT*ACC_W-1:0] coefs_a_reg;
    logic [ACC_W-1:0]            coef_sel;
    logic [ACC_W-1:0]            addend;

    // |x| * t as (~x) * t + t for negative x, so no separate negate
    assign neg_in      = in_acc[ACC_W-1];
    assign sel_in      = neg_in ? ~in_acc : in_acc;
    assign corr_in     = neg_in ? in_t : '0;
    assign prod_m_next = {{T_W{1'b0}}, sel_in} * {{ACC_W{1'b0}}, in_t}
                       + {{ACC_W{1'b0}}, corr_in};

    // round to nearest, ties away from zero, on the magnitude
    assign rnd_sum    = prod_m_reg + RND_HALF;
    assign mag_r_next = rnd_sum[T_FRAC +: ACC_W];

    // add or subtract the magnitude against the coefficient
    assign coef_sel   = coefs_r_reg[COEF_SEL*ACC_W +: ACC_W];
    assign addend     = neg_r_reg ? ~mag_r_reg : mag_r_reg;
    assign acc_a_next = $signed(coef_sel + addend + {{(ACC_W-1){1'b0}}, neg_r_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_m_reg <= 1'b0;
            vld_r_reg <= 1'b0;
            vld_a_reg <= 1'b0;
        end else if (en) begin
            vld_m_reg <= in_vld;
            vld_r_reg <= vld_m_reg;
            vld_a_reg <= vld_r_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_m_reg   <= neg_in;
            prod_m_reg  <= prod_m_next;
            t_m_reg     <= in_t;
            coefs_m_reg <= in_coefs;
            neg_r_reg   <= neg_m_reg;
            mag_r_reg   <= mag_r_next;
            t_r_reg     <= t_m_reg;
            coefs_r_reg <= coefs_m_reg;
            acc_a_reg   <= acc_a_next;
            t_a_reg     <= t_r_reg;
            coefs_a_reg <= coefs_r_reg;
        end
    end

    assign out_vld   = vld_a_reg;
    assign out_acc   = acc_a_reg;
    assign out_t     = t_a_reg;
    assign out_coefs = coefs_a_reg;

`ifndef SYNTHESIS
    // hold every stage valid while the pipeline is frozen
    a_freeze_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_m_reg) && $stable(vld_r_reg) && $stable(vld_a_reg))
        else $error("horner step valid moved while frozen");
`endif

endmodule

### src/crr_out_skid.sv
// ----------------------------------------------------------------------------
// crr_out_skid
// Output register with one skid entry; the ready toward the pipeline is
// registered so the result side never reaches back combinationally.
// ----------------------------------------------------------------------------
module crr_out_skid #(
    parameter int DATA_W = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_vld,
    input  logic [DATA_W-1:0] in_data,
    output logic              in_ready,
    output logic              out_vld,
    output logic [DATA_W-1:0] out_data,
    input  logic              out_ready
);

    logic              out_vld_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              skid_vld_reg;
    logic [DATA_W-1:0] skid_data_reg;
    logic              out_free;
    logic              in_xfer;

    assign in_ready = ~skid_vld_reg;
    assign out_free = ~out_vld_reg | out_ready;
    assign in_xfer  = in_vld & in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg  <= in_xfer;
            end
        end else if (in_xfer) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_vld_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_xfer) begin
                out_data_reg <= in_data;
            end
        end else if (in_xfer) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_data = out_data_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held while output register empty");

    a_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(in_ready) |-> $past(out_vld_reg && !out_ready && in_vld))
        else $error("skid filled without a stalled output");
`endif

endmodule

### src/catmull_rom_interpolator.sv
// ----------------------------------------------------------------------------
// catmull_rom_interpolator
// Uniform Catmull-Rom segment evaluation, one coordinate per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transfer carries one component of the four control points
//   p0..p3 (signed fixed point) and the segment parameter t (unsigned, with
//   1 << T_FRAC_BITS meaning 1.0; larger values are taken as 1.0). Send a
//   vector as consecutive transfers, one per component.
//   m_ channel: one transfer per input transfer, in order, carrying the
//   interpolated value and a saturation flag in m_tuser.
//   Pipeline: the result passes two coefficient stages, three stages for
//   each of the three Horner steps, and the output register before m_tvalid
//   can show it.
//   Throughput: one transfer per cycle unless stalled; the Horner multipliers
//   are unrolled into three pipelined steps, sharing nothing between items.
//   Stall: when m_tready is low, the output register holds and a single skid
//   entry catches the next result; once the skid entry is full, s_tready
//   drops and the whole pipeline freezes in place, losing nothing.
//   Reset: synchronous on aresetn low; clears all valid bits. The data
//   registers are not reset.
// ----------------------------------------------------------------------------
module catmull_rom_interpolator
    import crr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int T_W        = T_FRAC_BITS + 1,
    localparam int S_TDATA_W  = ((4 * COORD_WIDTH + T_W + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata, from bit 0 up: p0, p1, p2, p3, t, zero padding
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata, from bit 0 up: value, zero padding
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: saturated
    output logic                 m_tuser
);

    localparam int ACC_W  = COORD_WIDTH + ACC_GUARD_BITS;
    localparam int BUND_W = COEF_COUNT * ACC_W;
    localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [COORD_WIDTH-1:0] VAL_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] VAL_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic pipe_en;

    // ---------------- input field split and sign extension ----------------
    logic signed [COORD_WIDTH-1:0] p0_in, p1_in, p2_in, p3_in;
    logic [T_W-1:0]                t_in;
    logic signed [ACC_W-1:0]       p0_e, p1_e, p2_e, p3_e;
    logic                          t_over;
    logic [T_W-1:0]                t_clip;

    assign p0_in = $signed(s_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
    assign p1_in = $signed(s_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
    assign p2_in = $signed(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
    assign p3_in = $signed(s_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
    assign t_in  = s_tdata[4*COORD_WIDTH +: T_W];

    assign p0_e = ACC_W'(p0_in);
    assign p1_e = ACC_W'(p1_in);
    assign p2_e = ACC_W'(p2_in);
    assign p3_e = ACC_W'(p3_in);

    // clip t above 1.0 down to exactly 1.0
    assign t_over = t_in[T_FRAC_BITS] & (|t_in[T_FRAC_BITS-1:0]);
    assign t_clip = t_over ? T_ONE : t_in;

    // ---------------- stage 1: partial coefficient sums ----------------
    // d12 = p1-p2, cq = p3-p0, bq = 2p0-p3, bw = 4p2-5p1
    logic                    vld_s1_reg;
    logic signed [ACC_W-1:0] d12_s1_reg, cq_s1_reg, bq_s1_reg, bw_s1_reg;
    logic signed [ACC_W-1:0] a_s1_reg, p1x2_s1_reg;
    logic [T_W-1:0]          t_s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_s1_reg <= 1'b0;
        end else if (pipe_en) begin
            vld_s1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            d12_s1_reg  <= p1_e - p2_e;
            cq_s1_reg   <= p3_e - p0_e;
            bq_s1_reg   <= (p0_e <<< 1) - p3_e;
            bw_s1_reg   <= (p2_e <<< 2) - (p1_e <<< 2) - p1_e;
            a_s1_reg    <= p2_e - p0_e;
            p1x2_s1_reg <= p1_e <<< 1;
            t_s1_reg    <= t_clip;
        end
    end

    // ---------------- stage 2: final coefficients ----------------
    // c = -p0+3p1-3p2+p3, b = 2p0-5p1+4p2-p3
    logic                    vld_s2_reg;
    logic signed [ACC_W-1:0] c_s2_reg;
    logic [BUND_W-1:0]       coefs_s2_reg;
    logic [T_W-1:0]          t_s2_reg;
    logic signed [ACC_W-1:0] b_s2_next;

    assign b_s2_next = bq_s1_reg + bw_s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_s2_reg <= 1'b0;
        end else if (pipe_en) begin
            vld_s2_reg <= vld_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_s2_reg     <= cq_s1_reg + d12_s1_reg + (d12_s1_reg <<< 1);
            coefs_s2_reg <= {p1x2_s1_reg, a_s1_reg, b_s2_next};
            t_s2_reg     <= t_s1_reg;
        end
    end

    // ---------------- Horner steps: c -> +b -> +a -> +2p1 ----------------
    logic                    vld_h1, vld_h2, vld_h3;
    logic signed [ACC_W-1:0] acc_h1, acc_h2, acc_h3;
    logic [T_W-1:0]          t_h1, t_h2;
    logic [BUND_W-1:0]       coefs_h1, coefs_h2;

    crr_horner_step #(
        .ACC_W    (ACC_W),
        .T_FRAC   (T_FRAC_BITS),
        .COEF_SEL (COEF_SEL_B)
    ) u_step_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_vld    (vld_s2_reg),
        .in_acc    (c_s2_reg),
        .in_t      (t_s2_reg),
        .in_coefs  (coefs_s2_reg),
        .out_vld   (vld_h1),
        .out_acc   (acc_h1),
        .out_t     (t_h1),
        .out_coefs (coefs_h1)
    );

    crr_horner_step #(
        .ACC_W    (ACC_W),
        .T_FRAC   (T_FRAC_BITS),
        .COEF_SEL (COEF_SEL_A)
    ) u_step_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_vld    (vld_h1),
        .in_acc    (acc_h1),
        .in_t      (t_h1),
        .in_coefs  (coefs_h1),
        .out_vld   (vld_h2),
        .out_acc   (acc_h2),
        .out_t     (t_h2),
        .out_coefs (coefs_h2)
    );

    // last step: t and the coefficient bundle are no longer needed
    crr_horner_step #(
        .ACC_W    (ACC_W),
        .T_FRAC   (T_FRAC_BITS),
        .COEF_SEL (COEF_SEL_P1)
    ) u_step_p1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_vld    (vld_h2),
        .in_acc    (acc_h2),
        .in_t      (t_h2),
        .in_coefs  (coefs_h2),
        .out_vld   (vld_h3),
        .out_acc   (acc_h3),
        .out_t     (),
        .out_coefs ()
    );

    // ---------------- halve, round and saturate ----------------
    // Halving with ties away from zero: add one for non-negative values,
    // then shift arithmetically (a floor shift already rounds negative ties
    // away from zero).
    logic signed [ACC_W-1:0]       half_sum;
    logic signed [ACC_W-1:0]       half_res;
    logic [ACC_W-COORD_WIDTH:0]    high_bits;
    logic                          res_ovf;
    logic [COORD_WIDTH-1:0]        res_value;

    assign half_sum  = acc_h3 + $signed({{(ACC_W-1){1'b0}}, ~acc_h3[ACC_W-1]});
    assign half_res  = half_sum >>> 1;
    assign high_bits = half_res[ACC_W-1:COORD_WIDTH-1];
    assign res_ovf   = ~((&high_bits) | ~(|high_bits));
    assign res_value = res_ovf ? (half_res[ACC_W-1] ? VAL_MIN : VAL_MAX)
                               : half_res[COORD_WIDTH-1:0];

    // ---------------- output register with skid entry ----------------
    logic [COORD_WIDTH:0] out_data;

    crr_out_skid #(
        .DATA_W (COORD_WIDTH + 1)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_vld    (vld_h3),
        .in_data   ({res_ovf, res_value}),
        .in_ready  (pipe_en),
        .out_vld   (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    // the whole pipeline advances together; it freezes only on a full skid
    assign s_tready = pipe_en;
    assign m_tdata  = M_TDATA_W'(out_data[COORD_WIDTH-1:0]);
    assign m_tuser  = out_data[COORD_WIDTH];

`ifndef SYNTHESIS
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[COORD_WIDTH-1:0] == VAL_MAX || m_tdata[COORD_WIDTH-1:0] == VAL_MIN)
        else $error("saturation flag set on a value inside the range");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while no result is waiting");
`endif

endmodule
